>>> hdl/aupm_pkg.sv
// Shared types, constants and helper functions for the universe pixel mapper.
// It has no dependencies. The register file, the mapper core and the top level use it.
`default_nettype none
package aupm_pkg;

   localparam int WINDOW_UNIVERSES    = 9;
   localparam int PIXELS_PER_UNIVERSE = 170;
   localparam int MAX_LEDS            = 4096;

   localparam int SEQ_W    = 8;
   localparam int UNIV_W   = 15;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 12;
   localparam int LED_W    = 13;
   localparam int POS_W    = 10;
   localparam int POS_MAX  = (1 << POS_W) - 1;
   localparam int PIX_W    = $clog2(POS_MAX / 3 + 2);
   localparam int SLOT_W   = 2;
   localparam int OFFS_W   = $clog2(WINDOW_UNIVERSES + 1);
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SLOT_W-1:0] SLOT_RED   = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_GREEN = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_BLUE  = 2'd2;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_SHOW  = 1'b1;

   localparam logic REG_START_UNIVERSE = 1'b0;
   localparam logic REG_LED_COUNT      = 1'b1;

   typedef struct packed {
      logic [UNIV_W-1:0] start_universe;
      logic [LED_W-1:0]  led_count;
   } cfg_type;

   function automatic logic [LED_W-1:0] strip_limit(input logic [LED_W-1:0] leds);
      logic [LED_W-1:0] cap;
      cap = LED_W'(MAX_LEDS);
      strip_limit = (leds > cap) ? cap : leds;
   endfunction

endpackage
`default_nettype wire

>>> hdl/aupm_csr.sv
// Configuration register file with an APB-style write and read port.
// It depends on aupm_pkg for the register layout and the configuration struct.
`default_nettype none
module aupm_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [aupm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [aupm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [aupm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready,
   output aupm_pkg::cfg_type                        cfg
);

   aupm_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            aupm_pkg::REG_START_UNIVERSE: begin
               cfg_in.start_universe = csr_pwdata[aupm_pkg::UNIV_W-1:0];
            end
            aupm_pkg::REG_LED_COUNT: begin
               cfg_in.led_count = csr_pwdata[aupm_pkg::LED_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         aupm_pkg::REG_START_UNIVERSE: begin
            csr_prdata = aupm_pkg::CSR_DATA_W'(cfg_ff.start_universe);
         end
         aupm_pkg::REG_LED_COUNT: begin
            csr_prdata = aupm_pkg::CSR_DATA_W'(cfg_ff.led_count);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> hdl/aupm_core.sv
// Mapper datapath: an input register, the packet state, and a result register.
// It depends on aupm_pkg for widths, slot codes, result kinds and the strip limit.
`default_nettype none
module aupm_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire aupm_pkg::cfg_type                   cfg,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [aupm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [aupm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                     rsp_tuser
);

   localparam int SUM_W = aupm_pkg::UNIV_W + 1;

   // Input register.
   logic                              s1_valid_ff, s1_valid_in;
   logic [aupm_pkg::SEQ_W-1:0]        s1_seq_ff;
   logic [aupm_pkg::UNIV_W-1:0]       s1_univ_ff;
   logic [aupm_pkg::BYTE_W-1:0]       s1_byte_ff;
   logic                              s1_last_ff;

   // Packet state.
   logic [aupm_pkg::SEQ_W-1:0]        last_seq_ff, last_seq_in;
   logic [aupm_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [aupm_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic [aupm_pkg::PIX_W-1:0]        pix_ff, pix_in;
   logic [aupm_pkg::BYTE_W-1:0]       held_red_ff, held_red_in;
   logic [aupm_pkg::BYTE_W-1:0]       held_green_ff, held_green_in;

   // Result register.
   logic                              out_valid_ff, out_valid_in;
   logic                              out_kind_ff;
   logic [aupm_pkg::INDEX_W-1:0]      out_index_ff;
   logic [aupm_pkg::BYTE_W-1:0]       out_red_ff, out_green_ff, out_blue_ff;

   logic                              out_take;
   logic                              advance;
   logic                              req_accept;
   logic                              show;
   logic                              active;
   logic                              in_window;
   logic                              mapped;
   logic                              write_px;
   logic [SUM_W-1:0]                  window_end;
   logic [aupm_pkg::OFFS_W-1:0]       offset;
   logic [aupm_pkg::LED_W-1:0]        limit;
   logic [aupm_pkg::LED_W-1:0]        map_end;
   logic [aupm_pkg::LED_W-1:0]        base;
   logic [aupm_pkg::LED_W-1:0]        index;

   assign out_take   = !out_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_take;
   assign req_tready = !s1_valid_ff || out_take;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_comb begin
      show       = (pos_ff == '0) && (s1_seq_ff != last_seq_ff);
      active     = (pos_ff != aupm_pkg::POS_W'(aupm_pkg::POS_MAX));
      window_end = SUM_W'(cfg.start_universe) + SUM_W'(aupm_pkg::WINDOW_UNIVERSES);
      in_window  = (s1_univ_ff >= cfg.start_universe) && (SUM_W'(s1_univ_ff) < window_end);
      offset     = aupm_pkg::OFFS_W'(s1_univ_ff - cfg.start_universe);
      limit      = aupm_pkg::strip_limit(cfg.led_count);
      map_end    = aupm_pkg::LED_W'((aupm_pkg::LED_W'(offset) + aupm_pkg::LED_W'(1))
                   * aupm_pkg::LED_W'(aupm_pkg::PIXELS_PER_UNIVERSE));
      mapped     = (map_end <= limit);
      base       = mapped ? aupm_pkg::LED_W'(aupm_pkg::LED_W'(offset)
                   * aupm_pkg::LED_W'(aupm_pkg::PIXELS_PER_UNIVERSE)) : '0;
      index      = base + aupm_pkg::LED_W'(pix_ff);
      write_px   = active && (slot_ff == aupm_pkg::SLOT_BLUE) && in_window
                   && (index < limit) && !show;
   end

   always_comb begin
      last_seq_in   = last_seq_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      pix_in        = pix_ff;
      held_red_in   = held_red_ff;
      held_green_in = held_green_ff;
      if (advance) begin
         if (show) begin
            last_seq_in = s1_seq_ff;
         end
         if (active) begin
            case (slot_ff)
               aupm_pkg::SLOT_RED: begin
                  held_red_in = s1_byte_ff;
               end
               aupm_pkg::SLOT_GREEN: begin
                  held_green_in = s1_byte_ff;
               end
               default: begin
                  held_red_in = held_red_ff;
               end
            endcase
         end
         if (s1_last_ff) begin
            pos_in  = '0;
            slot_in = aupm_pkg::SLOT_RED;
            pix_in  = '0;
         end else if (active) begin
            pos_in = pos_ff + 1'b1;
            if (slot_ff == aupm_pkg::SLOT_BLUE) begin
               slot_in = aupm_pkg::SLOT_RED;
               pix_in  = pix_ff + 1'b1;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
      end
   end

   assign out_valid_in = out_take ? (advance && (show || write_px)) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_seq_ff  <= '0;
         pos_ff       <= '0;
         slot_ff      <= aupm_pkg::SLOT_RED;
         pix_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         last_seq_ff  <= last_seq_in;
         pos_ff       <= pos_in;
         slot_ff      <= slot_in;
         pix_ff       <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      held_red_ff   <= held_red_in;
      held_green_ff <= held_green_in;
      if (req_accept) begin
         s1_seq_ff  <= req_tdata[7:0];
         s1_univ_ff <= req_tdata[22:8];
         s1_byte_ff <= req_tdata[30:23];
         s1_last_ff <= req_tlast;
      end
      if (out_take) begin
         if (show) begin
            out_kind_ff  <= aupm_pkg::KIND_SHOW;
            out_index_ff <= '0;
            out_red_ff   <= '0;
            out_green_ff <= '0;
            out_blue_ff  <= '0;
         end else begin
            out_kind_ff  <= aupm_pkg::KIND_PIXEL;
            out_index_ff <= index[aupm_pkg::INDEX_W-1:0];
            out_red_ff   <= held_red_ff;
            out_green_ff <= held_green_ff;
            out_blue_ff  <= s1_byte_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {4'b0000, out_blue_ff, out_green_ff, out_red_ff, out_index_ff};

endmodule
`default_nettype wire

>>> hdl/artnet_universe_pixel_mapper_top.sv
// Top level of the universe pixel mapper: register file plus mapper core.
// It depends on aupm_pkg, aupm_csr and aupm_core.
//
// The mapper takes one payload byte per transaction and emits either a show-frame
// transaction, when the first byte of a packet carries a new sequence number, or an
// RGB pixel write on every third byte of a packet whose universe lies in the
// nine-universe window above start_universe. It accepts one transaction every clock
// cycle; each byte passes through an input register and then a result register, and
// both registers hold under back-pressure from the result side. Writes at or beyond
// led_count (capped at 4096) are dropped, as is a trailing partial pixel. The user
// must write the registers only while no transaction is in flight; the block itself
// does not enforce this.
`default_nettype none
module artnet_universe_pixel_mapper_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: sequence_req[7:0], universe[22:8], data_byte[30:23], zero[31].
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [aupm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                req_tlast,
   // rsp_tdata: pixel_index[11:0], red[19:12], green[27:20], blue[35:28], zero[39:36].
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [aupm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: result_kind[0].
   output logic                                     rsp_tuser,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [aupm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [aupm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [aupm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   aupm_pkg::cfg_type cfg;

   aupm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   aupm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_show_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == aupm_pkg::KIND_SHOW)) |-> (rsp_tdata == '0))
      else $error("show transaction carries a nonzero payload");

   a_pixel_within_strip: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == aupm_pkg::KIND_PIXEL)) |->
      (aupm_pkg::LED_W'(rsp_tdata[aupm_pkg::INDEX_W-1:0])
       < aupm_pkg::strip_limit(cfg.led_count)))
      else $error("pixel write at or beyond the strip limit");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while the result register is empty");
`endif

endmodule
`default_nettype wire

>>> verif/aupm_checker.sv
`timescale 1ns / 100ps
// Checker for the universe pixel mapper: watches the request, result and register ports,
// predicts every show-frame and pixel-write transaction and compares them in order.
// Depends on aupm_pkg only.
module aupm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [aupm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [aupm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [aupm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [aupm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending
);
   import aupm_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] index;
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
   } led_write_type;

   led_write_type     expected_writes[$];
   logic [UNIV_W-1:0] start_uni;
   logic [LED_W-1:0]  leds;
   logic [SEQ_W-1:0]  last_seq;
   logic [POS_W-1:0]  byte_pos;
   logic [BYTE_W-1:0] held_red;
   logic [BYTE_W-1:0] held_green;

   task automatic report(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic predict_byte(input logic [SEQ_W-1:0] seq, input logic [UNIV_W-1:0] uni,
                               input logic [BYTE_W-1:0] data, input logic last);
      int unsigned lim;
      int unsigned offset;
      int unsigned base;
      int unsigned idx;
      logic [SLOT_W-1:0] slot;
      bit produced;
      produced = 0;
      if (byte_pos == 0 && seq != last_seq) begin
         last_seq = seq;
         expected_writes.push_back('{KIND_SHOW, '0, '0, '0, '0});
         produced = 1;
      end
      if (byte_pos < POS_MAX) begin
         slot = SLOT_W'(byte_pos % 3);
         case (slot)
            SLOT_RED: held_red = data;
            SLOT_GREEN: held_green = data;
            default: begin
               if (int'(uni) >= int'(start_uni) &&
                   int'(uni) < int'(start_uni) + WINDOW_UNIVERSES) begin
                  lim = (int'(leds) > MAX_LEDS) ? MAX_LEDS : int'(leds);
                  offset = int'(uni) - int'(start_uni);
                  base = (offset < lim / PIXELS_PER_UNIVERSE) ? offset * PIXELS_PER_UNIVERSE : 0;
                  idx = base + byte_pos / 3;
                  if (idx < lim && !produced)
                     expected_writes.push_back('{KIND_PIXEL, INDEX_W'(idx), held_red, held_green,
                                                 data});
               end
            end
         endcase
      end
      if (last)
         byte_pos = '0;
      else if (byte_pos < POS_MAX)
         byte_pos = byte_pos + 1'b1;
   endtask

   task automatic check_result();
      led_write_type want;
      if (expected_writes.size() == 0) begin
         report("result with nothing pending, index", rsp_tdata[11:0], 0);
      end else begin
         want = expected_writes.pop_front();
         if (rsp_tuser != want.kind)
            report("result_kind", rsp_tuser, want.kind);
         if (rsp_tdata[11:0] != want.index)
            report("pixel_index", rsp_tdata[11:0], want.index);
         if (rsp_tdata[19:12] != want.red)
            report("red", rsp_tdata[19:12], want.red);
         if (rsp_tdata[27:20] != want.green)
            report("green", rsp_tdata[27:20], want.green);
         if (rsp_tdata[35:28] != want.blue)
            report("blue", rsp_tdata[35:28], want.blue);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_writes.delete();
         start_uni = '0;
         leds = '0;
         last_seq = '0;
         byte_pos = '0;
         held_red = '0;
         held_green = '0;
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            predict_byte(req_tdata[7:0], req_tdata[22:8], req_tdata[30:23], req_tlast);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[1:0] == 2'b00) begin
            case (csr_paddr[2])
               REG_START_UNIVERSE: start_uni = csr_pwdata[UNIV_W-1:0];
               REG_LED_COUNT: leds = csr_pwdata[LED_W-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_writes.size();
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Top of the universe pixel mapper testbench: clock, reset, register setup and byte stimulus.
// Depends on aupm_pkg, artnet_universe_pixel_mapper_top and aupm_checker.
module tb;
   import aupm_pkg::*;

   localparam int PHASE_ITEMS     = 80;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 6;
   localparam int CYCLE_LIMIT     = 600000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;

   bit                    tx_idle_en;
   bit                    rx_idle_en;
   bit                    hold_off_req;
   int                    items_sent;
   logic [SEQ_W-1:0]      cur_seq;
   logic [UNIV_W-1:0]     cfg_start;

   artnet_universe_pixel_mapper_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   aupm_checker pixel_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("artnet_universe_pixel_mapper_top verification failed");
      $finish;
   end

   // The result side stalls in random bursts, or for one long stretch on request.
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 0;
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [SEQ_W-1:0] seq, input logic [UNIV_W-1:0] uni,
                            input logic [BYTE_W-1:0] data, input bit last);
      int gap;
      @(negedge clock);
      if (tx_idle_en && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {1'b0, data, uni, seq};
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Unused upper data bits carry random values; the registers must ignore them.
   task automatic configure(input logic [UNIV_W-1:0] start, input logic [LED_W-1:0] leds);
      logic [31:0] junk;
      wait_drained();
      cfg_start = start;
      junk = $urandom;
      csr_write(REG_START_UNIVERSE, {junk[31:UNIV_W], start});
      junk = $urandom;
      csr_write(REG_LED_COUNT, {junk[31:LED_W], leds});
   endtask

   task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [UNIV_W-1:0] uni,
                              input int len, input bit noisy);
      logic [UNIV_W-1:0] u;
      logic [SEQ_W-1:0]  s;
      for (int i = 0; i < len; i++) begin
         u = uni;
         s = seq;
         if (noisy && $urandom_range(0, 15) == 0)
            u = uni + UNIV_W'($urandom_range(0, 9));
         if (noisy && $urandom_range(0, 31) == 0)
            s = SEQ_W'($urandom);
         send_byte(s, u, BYTE_W'($urandom), i == len - 1);
      end
   endtask

   task automatic random_packet(input int max_len);
      logic [UNIV_W-1:0] uni;
      int pick;
      int len;
      if ($urandom_range(0, 9) >= 4)
         cur_seq = SEQ_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 8)
         uni = cfg_start + UNIV_W'($urandom_range(0, 8));
      else if (pick == 8)
         uni = $urandom_range(0, 1) ? cfg_start - 1'b1 : cfg_start + UNIV_W'(9);
      else
         uni = UNIV_W'($urandom);
      pick = $urandom_range(0, 19);
      if (pick == 0)
         len = 510;
      else if (pick < 14)
         len = 3 * $urandom_range(1, 14);
      else
         len = $urandom_range(1, 45);
      if (len > max_len)
         len = max_len;
      send_packet(cur_seq, uni, len, $urandom_range(0, 4) == 0);
   endtask

   task automatic random_phase(input int budget);
      int first;
      first = items_sent;
      while (items_sent - first < budget) random_packet(budget - (items_sent - first));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      tx_idle_en = 1;
      rx_idle_en = 1;
      hold_off_req = 0;
      items_sent = 0;
      cur_seq = '0;
      cfg_start = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed: window edges, partial pixel, universe switch mid-packet, data extremes.
      configure(15'd5, 13'd4096);
      send_byte(8'd0, 15'd5, 8'h00, 0);
      send_byte(8'd0, 15'd5, 8'hFF, 0);
      send_byte(8'd0, 15'd5, 8'h55, 0);
      send_byte(8'd0, 15'd5, 8'hFF, 0);
      send_byte(8'd0, 15'd5, 8'h00, 0);
      send_byte(8'd0, 15'd5, 8'hAA, 1);
      send_byte(8'd255, 15'd13, 8'h01, 0);
      send_byte(8'd255, 15'd13, 8'h02, 0);
      send_byte(8'd255, 15'd13, 8'h03, 0);
      send_byte(8'd255, 15'd13, 8'hFE, 1);
      send_byte(8'd255, 15'd14, 8'h11, 0);
      send_byte(8'd255, 15'd14, 8'h22, 0);
      send_byte(8'd255, 15'd14, 8'h33, 1);
      send_byte(8'd1, 15'd4, 8'h44, 0);
      send_byte(8'd1, 15'd4, 8'h55, 0);
      send_byte(8'd1, 15'd4, 8'h66, 1);
      send_byte(8'd1, 15'd5, 8'h77, 0);
      send_byte(8'd1, 15'd14, 8'h88, 0);
      send_byte(8'd1, 15'd6, 8'h99, 1);
      send_byte(8'd2, 15'h7FFF, 8'hFF, 0);
      send_byte(8'd2, 15'h7FFF, 8'h00, 0);
      send_byte(8'd2, 15'h7FFF, 8'hFF, 1);
      send_byte(8'd2, 15'd5, 8'h80, 1);
      cur_seq = 8'd2;

      configure(15'd0, 13'd0);
      random_phase(PHASE_ITEMS);

      // Long result-side stall while bytes keep coming, so the input stalls too.
      configure(15'd0, 13'd340);
      tx_idle_en = 0;
      hold_off_req = 1;
      random_phase(PHASE_ITEMS);
      tx_idle_en = 1;

      configure(15'h7FFF, 13'd8191);
      random_phase(PHASE_ITEMS / 2);
      wait_drained();
      random_phase(PHASE_ITEMS / 2);

      configure(15'd32760, 13'd1530);
      random_phase(PHASE_ITEMS);

      configure(15'd100, 13'd7);
      random_phase(PHASE_ITEMS);

      configure(UNIV_W'($urandom), LED_W'($urandom_range(0, 8191)));
      random_phase(PHASE_ITEMS);

      // One over-long packet runs the byte position into saturation.
      configure(15'd12345, 13'd4095);
      cur_seq = cur_seq + 1'b1;
      send_packet(cur_seq, 15'd12345 + UNIV_W'($urandom_range(0, 8)), 1030, 0);
      random_phase(PHASE_ITEMS);

      configure(15'd0, 13'd4096);
      tx_idle_en = 0;
      rx_idle_en = 0;
      random_phase(PHASE_ITEMS);

      wait_drained();
      if (fail_count == 0)
         $display("artnet_universe_pixel_mapper_top verification clean");
      else
         $display("artnet_universe_pixel_mapper_top verification failed");
      $finish;
   end

endmodule
